FILE: design/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types, widths and codes for the descriptor slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

    // built capacity of the slot pool
    localparam int MAX_SLOTS = 1024;

    // fixed field widths
    localparam int IDX_W   = 10;
    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 11;
    localparam int BYTES_W = 13;
    localparam int PROD_W  = BYTES_W + IDX_W;

    // stack pointer and fill count widths follow the capacity
    localparam int PTR_W   = $clog2(MAX_SLOTS);
    localparam int DEPTH_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 2'd2;

    // configuration reset values
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 13'd64;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [BYTES_W-1:0] t_bytes;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [CMP_W-1:0]   t_cmp;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ADD
    } t_state;

    typedef struct packed {
        t_opcode opcode;
        t_idx    release_index;
    } t_cmd;

    typedef struct packed {
        t_idx    slot_index;
        t_addr   slot_address;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

FILE: design/dsa_stack_ram.sv
// ----------------------------------------------------------------------------
// dsa_stack_ram
// Simple dual-port memory holding the free index stack, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsa_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/dsa_addr_calc.sv
// ----------------------------------------------------------------------------
// dsa_addr_calc
// Slot address: registered slot size times index, then base added.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsa_addr_calc (
    input  wire logic           i_clk,
    input  wire dsa_pkg::t_bytes i_slot_bytes,
    input  wire dsa_pkg::t_idx   i_idx,
    input  wire dsa_pkg::t_addr  i_base,
    output dsa_pkg::t_addr       o_addr
);

    dsa_pkg::t_prod r_prod;

    // byte offset of the slot
    always_ff @(posedge i_clk) begin
        r_prod <= dsa_pkg::t_prod'(i_slot_bytes) * dsa_pkg::t_prod'(i_idx);
    end

    // base plus offset, wraps at the address width
    assign o_addr = i_base + dsa_pkg::t_addr'(r_prod);

endmodule

`default_nettype wire

FILE: design/descriptor_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_unit
// LIFO free-list slot allocator with a high-water counter and slot addresses.
// ----------------------------------------------------------------------------
// One item at a time: start is taken when busy is low. A free, or an
// allocate that finds no slot, gives its result on o_result_valid in the
// cycle after acceptance with busy staying low. An allocate served by the
// high-water counter raises busy and gives its result after the states
// S_MUL (multiply stage) and S_ADD (add stage); one served from the free
// stack passes first through S_READ, the registered read of the stack
// memory. The result is shown for exactly one cycle and cannot be stalled.
// Configuration writes are always ready and are applied at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_allocator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire dsa_pkg::t_cmd                       i_cmd,
    output logic                                     o_result_valid,
    output dsa_pkg::t_result                         o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dsa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    dsa_pkg::t_state  r_state, n_state;
    dsa_pkg::t_depth  r_depth, n_depth;
    dsa_pkg::t_depth  r_hw, n_hw;
    dsa_pkg::t_idx    r_idx, n_idx;
    dsa_pkg::t_result r_res, n_res;
    logic             r_res_valid, n_res_valid;

    dsa_pkg::t_count  r_slot_count;
    dsa_pkg::t_bytes  r_slot_bytes;
    dsa_pkg::t_addr   r_base;

    logic             ram_we;
    dsa_pkg::t_ptr    ram_waddr;
    logic             ram_re;
    dsa_pkg::t_ptr    ram_raddr;
    dsa_pkg::t_idx    ram_rdata;
    dsa_pkg::t_addr   calc_addr;

    logic             accept;
    logic             hw_room;
    logic             rel_bad;
    logic             stack_full;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= dsa_pkg::SLOT_COUNT_RST;
            r_slot_bytes <= dsa_pkg::SLOT_BYTES_RST;
            r_base       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == dsa_pkg::CFG_SLOT_COUNT) begin
                r_slot_count <= i_cfg_data[dsa_pkg::COUNT_W-1:0];
            end
            if (i_cfg_index == dsa_pkg::CFG_SLOT_BYTES) begin
                r_slot_bytes <= i_cfg_data[dsa_pkg::BYTES_W-1:0];
            end
            if (i_cfg_index == dsa_pkg::CFG_BASE_ADDR) begin
                r_base <= i_cfg_data[dsa_pkg::ADDR_W-1:0];
            end
        end
    end

    // free index stack
    dsa_stack_ram #(
        .DEPTH (dsa_pkg::MAX_SLOTS),
        .WIDTH (dsa_pkg::IDX_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.release_index),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // slot address datapath
    dsa_addr_calc u_calc (
        .i_clk        (i_clk),
        .i_slot_bytes (r_slot_bytes),
        .i_idx        (r_idx),
        .i_base       (r_base),
        .o_addr       (calc_addr)
    );

    // request checks
    assign busy       = (r_state != dsa_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign hw_room    = (dsa_pkg::t_cmp'(r_hw) < dsa_pkg::t_cmp'(r_slot_count)) &&
                        (r_hw < dsa_pkg::t_depth'(dsa_pkg::MAX_SLOTS));
    assign rel_bad    = (dsa_pkg::t_cmp'(i_cmd.release_index) >= dsa_pkg::t_cmp'(r_hw));
    assign stack_full = (r_depth >= dsa_pkg::t_depth'(dsa_pkg::MAX_SLOTS));
    assign ram_waddr  = dsa_pkg::t_ptr'(r_depth);
    assign ram_raddr  = dsa_pkg::t_ptr'(r_depth - 1'b1);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsa_pkg::S_IDLE;
            r_depth     <= '0;
            r_hw        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_hw        <= n_hw;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_hw        = r_hw;
        n_idx       = r_idx;
        n_res       = r_res;
        n_res_valid = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            dsa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == dsa_pkg::OP_ALLOC) begin
                        if (r_depth != '0) begin
                            // pop most recently freed index
                            n_depth = r_depth - 1'b1;
                            ram_re  = 1'b1;
                            n_state = dsa_pkg::S_READ;
                        end else if (hw_room) begin
                            // fresh index from the high-water counter
                            n_idx   = r_hw[dsa_pkg::IDX_W-1:0];
                            n_hw    = r_hw + 1'b1;
                            n_state = dsa_pkg::S_MUL;
                        end else begin
                            n_res.slot_index   = '0;
                            n_res.slot_address = '0;
                            n_res.status       = dsa_pkg::ST_EXHAUSTED;
                            n_res_valid        = 1'b1;
                        end
                    end else begin
                        n_res.slot_index   = '0;
                        n_res.slot_address = '0;
                        if (rel_bad) begin
                            n_res.status = dsa_pkg::ST_BAD_INDEX;
                        end else if (stack_full) begin
                            n_res.status = dsa_pkg::ST_FULL;
                        end else begin
                            // push released index
                            ram_we       = 1'b1;
                            n_depth      = r_depth + 1'b1;
                            n_res.status = dsa_pkg::ST_OK;
                        end
                        n_res_valid = 1'b1;
                    end
                end
            end
            dsa_pkg::S_READ: begin
                n_idx   = ram_rdata;
                n_state = dsa_pkg::S_MUL;
            end
            dsa_pkg::S_MUL: begin
                n_state = dsa_pkg::S_ADD;
            end
            dsa_pkg::S_ADD: begin
                n_res.slot_index   = r_idx;
                n_res.slot_address = calc_addr;
                n_res.status       = dsa_pkg::ST_OK;
                n_res_valid        = 1'b1;
                n_state            = dsa_pkg::S_IDLE;
            end
            default: begin
                n_state = dsa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

`ifndef SYNTHESIS
    // a granted allocate always ends in a result
    a_add_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsa_pkg::S_ADD) |=> (o_result_valid &&
            o_result.status == dsa_pkg::ST_OK))
        else $error("allocate finished without a result");

    // stack fill never exceeds capacity
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= dsa_pkg::t_depth'(dsa_pkg::MAX_SLOTS))
        else $error("free stack overfilled");

    // high-water mark never passes capacity
    a_depth_vs_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hw <= dsa_pkg::t_depth'(dsa_pkg::MAX_SLOTS)))
        else $error("high-water mark beyond capacity");

    // a pop lowers the fill count by one
    a_pop_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.opcode == dsa_pkg::OP_ALLOC && r_depth != '0) |=>
            (r_depth == $past(r_depth) - 1'b1 && r_state == dsa_pkg::S_READ))
        else $error("stack pop did not update fill count");

    // no new result while an allocate is in flight, except at its end
    a_no_result_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsa_pkg::S_READ || r_state == dsa_pkg::S_MUL) |=>
            !o_result_valid)
        else $error("result issued mid allocate");
`endif

endmodule

`default_nettype wire
